>>> design/rrc_pkg.sv
// Shared types and constants for the rectangle raster canvas.
// Holds command codes, register indexes, FSM states and size defaults.
// No dependencies.
package rrc_pkg;

  // Default sizes, handed to the top-level parameters
  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_HEIGHT = 512;
  localparam int DEF_FRAC_BITS  = 8;

  // Fixed field widths
  localparam int COORD_W = 24;
  localparam int CHAR_W  = 8;
  localparam int RDIDX_W = 9;
  localparam int SIZE_W  = 10;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 2;

  // Register reset values
  localparam logic [SIZE_W-1:0] RST_CANVAS_WIDTH    = SIZE_W'(512);
  localparam logic [SIZE_W-1:0] RST_CANVAS_HEIGHT   = SIZE_W'(512);
  localparam logic [CHAR_W-1:0] RST_BACKGROUND_CHAR = CHAR_W'(32);

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_OUTLINE = 2'd1,
    CMD_FILL    = 2'd2,
    CMD_READ    = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CANVAS_WIDTH    = 2'd0,
    REG_CANVAS_HEIGHT   = 2'd1,
    REG_BACKGROUND_CHAR = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SETUP,
    ST_ROW,
    ST_COL,
    ST_READ,
    ST_RDATA,
    ST_DONE
  } state_t;

  // Order of bound computations on the shared adder
  typedef enum logic [2:0] {
    SU_RIGHT,
    SU_BOTTOM,
    SU_LEFT_IN,
    SU_RIGHT_IN,
    SU_TOP_IN,
    SU_BOTTOM_IN
  } setup_step_t;

endpackage

>>> design/rrc_in_if.sv
// Command channel of the rectangle raster canvas: valid/ready plus one word.
// Depends on rrc_pkg for field widths.
interface rrc_in_if
  import rrc_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic [1:0]                 command;
  logic signed [COORD_W-1:0]  rect_left;
  logic signed [COORD_W-1:0]  rect_top;
  logic signed [COORD_W-1:0]  rect_span_x;
  logic signed [COORD_W-1:0]  rect_span_y;
  logic [CHAR_W-1:0]          paint_char;
  logic [RDIDX_W-1:0]         read_row;
  logic [RDIDX_W-1:0]         read_col;

  modport source (
    output valid, command, rect_left, rect_top, rect_span_x, rect_span_y,
           paint_char, read_row, read_col,
    input  ready
  );
  modport sink (
    input  valid, command, rect_left, rect_top, rect_span_x, rect_span_y,
           paint_char, read_row, read_col,
    output ready
  );
endinterface

>>> design/rrc_out_if.sv
// Result channel of the rectangle raster canvas: valid/ready plus one word.
// Depends on rrc_pkg for field widths.
interface rrc_out_if
  import rrc_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] pixel_char;
  logic              status;

  modport source (output valid, pixel_char, status, input ready);
  modport sink   (input valid, pixel_char, status, output ready);
endinterface

>>> design/rrc_ram.sv
// Generic single-port RAM, one write or read per cycle, registered read data.
// No dependencies.
module rrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                         wdata,
  output logic [WIDTH-1:0]                         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> design/rectangle_raster_canvas.sv
// Rectangle raster canvas top level: sequencer, shared adder/comparator, canvas RAM.
// Depends on rrc_pkg, rrc_in_if, rrc_out_if and rrc_ram.
//
// A byte canvas of MAX_WIDTH x MAX_HEIGHT held in one single-port RAM. One
// command word is taken at a time; the block is busy until its result word
// is queued in the output register, and the next command can be taken while
// that result waits. All canvas work goes through the one RAM port, one pixel
// per cycle. Clear: every canvas address is written with the background
// character. Draw: the rectangle bounds are worked out on the shared adder,
// then each canvas row is tested, and every row the rectangle touches is
// walked across the canvas width. A rectangle with a non-positive span goes
// straight to a result word with error status. Read pixel: one RAM read, or
// a zero pixel when the pixel lies outside the canvas. Canvas contents are
// defined only after a clear.
module rectangle_raster_canvas
  import rrc_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  rrc_in_if.sink                in_ch,
  rrc_out_if.source             out_ch
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
  localparam int HCNT_W = $clog2(MAX_HEIGHT + 1);
  localparam int DIM_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int CMP_W  = (DIM_W + FRAC_BITS + 2 > COORD_W + 3) ?
                          DIM_W + FRAC_BITS + 2 : COORD_W + 3;
  localparam logic signed [CMP_W-1:0] ONE_FX = CMP_W'(64'd1 << FRAC_BITS);

  // Configuration registers
  logic [SIZE_W-1:0] canvas_width;
  logic [SIZE_W-1:0] canvas_height;
  logic [CHAR_W-1:0] background_char;

  // Sequencer
  state_t      state, state_next;
  setup_step_t setup_step;

  // Latched command word
  cmd_t                     cmd_q;
  logic [CHAR_W-1:0]        paint_q;
  logic [RDIDX_W-1:0]       rd_row_q;
  logic [RDIDX_W-1:0]       rd_col_q;
  logic signed [CMP_W-1:0]  span_x_q;
  logic signed [CMP_W-1:0]  span_y_q;

  // Rectangle bounds in fixed point
  logic signed [CMP_W-1:0]  x_lo, x_hi, x_lo_e, x_hi_e;
  logic signed [CMP_W-1:0]  y_lo, y_hi, y_lo_e, y_hi_e;

  // Scan counters
  logic [ADDR_W-1:0] clr_addr;
  logic [ROW_W-1:0]  walk_row;
  logic [COL_W-1:0]  walk_col;
  logic              row_edge;

  // Pending and output result
  logic [CHAR_W-1:0] pend_pix;
  logic              pend_status;
  logic              out_valid;
  logic [CHAR_W-1:0] out_pix;
  logic              out_status;

  // Shared units and decode
  logic [WCNT_W-1:0]       eff_w;
  logic [HCNT_W-1:0]       eff_h;
  logic                    col_last, row_last, clr_last;
  logic                    in_fire, out_free, bad_rect, read_in_range;
  logic signed [CMP_W-1:0] add_a, add_b, add_sum;
  logic                    add_sub;
  logic signed [CMP_W-1:0] cmp_v, cmp_lo, cmp_hi, cmp_lo_e, cmp_hi_e;
  logic                    cmp_in, cmp_edge, paint_hit;
  logic [ADDR_W-1:0]       read_addr, draw_addr;

  // RAM port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [CHAR_W-1:0] ram_wdata, ram_rdata;

  // Canvas size with out-of-range values pulled into 1..MAX
  always_comb begin
    if (canvas_width == '0) eff_w = WCNT_W'(1);
    else if (32'(canvas_width) > 32'(MAX_WIDTH)) eff_w = WCNT_W'(MAX_WIDTH);
    else eff_w = WCNT_W'(canvas_width);
    if (canvas_height == '0) eff_h = HCNT_W'(1);
    else if (32'(canvas_height) > 32'(MAX_HEIGHT)) eff_h = HCNT_W'(MAX_HEIGHT);
    else eff_h = HCNT_W'(canvas_height);
  end

  assign col_last = (32'(walk_col) + 32'd1) == 32'(eff_w);
  assign row_last = (32'(walk_row) + 32'd1) == 32'(eff_h);
  assign clr_last = 32'(clr_addr) == 32'(DEPTH - 1);

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid || out_ch.ready;
  assign bad_rect = (in_ch.rect_span_x <= 24'sd0) || (in_ch.rect_span_y <= 24'sd0);
  assign read_in_range = (32'(rd_row_q) < 32'(eff_h)) && (32'(rd_col_q) < 32'(eff_w));

  assign read_addr = ADDR_W'(32'(rd_row_q) * 32'(MAX_WIDTH) + 32'(rd_col_q));
  assign draw_addr = ADDR_W'(32'(walk_row) * 32'(MAX_WIDTH) + 32'(walk_col));

  // Shared adder for the rectangle bounds
  always_comb begin
    unique case (setup_step)
      SU_RIGHT:     begin add_a = x_lo; add_b = span_x_q; add_sub = 1'b0; end
      SU_BOTTOM:    begin add_a = y_lo; add_b = span_y_q; add_sub = 1'b0; end
      SU_LEFT_IN:   begin add_a = x_lo; add_b = ONE_FX;   add_sub = 1'b0; end
      SU_RIGHT_IN:  begin add_a = x_hi; add_b = ONE_FX;   add_sub = 1'b1; end
      SU_TOP_IN:    begin add_a = y_lo; add_b = ONE_FX;   add_sub = 1'b0; end
      SU_BOTTOM_IN: begin add_a = y_hi; add_b = ONE_FX;   add_sub = 1'b1; end
      default:      begin add_a = x_lo; add_b = span_x_q; add_sub = 1'b0; end
    endcase
    add_sum = add_sub ? (add_a - add_b) : (add_a + add_b);
  end

  // Shared comparator: row test in ST_ROW, column test otherwise
  always_comb begin
    if (state == ST_ROW) begin
      cmp_v    = $signed(CMP_W'(walk_row) << FRAC_BITS);
      cmp_lo   = y_lo;
      cmp_hi   = y_hi;
      cmp_lo_e = y_lo_e;
      cmp_hi_e = y_hi_e;
    end else begin
      cmp_v    = $signed(CMP_W'(walk_col) << FRAC_BITS);
      cmp_lo   = x_lo;
      cmp_hi   = x_hi;
      cmp_lo_e = x_lo_e;
      cmp_hi_e = x_hi_e;
    end
    cmp_in   = (cmp_v >= cmp_lo) && (cmp_v <= cmp_hi);
    cmp_edge = (cmp_v < cmp_lo_e) || (cmp_v > cmp_hi_e);
  end

  assign paint_hit = cmp_in && ((cmd_q == CMD_FILL) || row_edge || cmp_edge);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (cmd_t'(in_ch.command))
            CMD_CLEAR:   state_next = ST_CLEAR;
            CMD_READ:    state_next = ST_READ;
            CMD_OUTLINE,
            CMD_FILL:    state_next = bad_rect ? ST_DONE : ST_SETUP;
          endcase
        end
      end
      ST_CLEAR: if (clr_last) state_next = ST_DONE;
      ST_SETUP: if (setup_step == SU_BOTTOM_IN) state_next = ST_ROW;
      ST_ROW: begin
        if (cmp_in) state_next = ST_COL;
        else if (row_last) state_next = ST_DONE;
      end
      ST_COL: begin
        if (col_last) state_next = row_last ? ST_DONE : ST_ROW;
      end
      ST_READ:  state_next = read_in_range ? ST_RDATA : ST_DONE;
      ST_RDATA: state_next = ST_DONE;
      ST_DONE:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: RAM port and command ready
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = read_addr;
    ram_wdata = paint_q;
    in_ch.ready = 1'b0;
    unique case (state)
      ST_IDLE:  in_ch.ready = 1'b1;
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_addr;
        ram_wdata = background_char;
      end
      ST_COL: begin
        ram_we   = paint_hit;
        ram_addr = draw_addr;
      end
      ST_SETUP, ST_ROW, ST_READ, ST_RDATA, ST_DONE: ;
      default: ;
    endcase
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width    <= RST_CANVAS_WIDTH;
      canvas_height   <= RST_CANVAS_HEIGHT;
      background_char <= RST_BACKGROUND_CHAR;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CANVAS_WIDTH:    canvas_width    <= cfg_data;
        REG_CANVAS_HEIGHT:   canvas_height   <= cfg_data;
        REG_BACKGROUND_CHAR: background_char <= cfg_data[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      setup_step <= SU_RIGHT;
      clr_addr   <= '0;
      walk_row   <= '0;
      walk_col   <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && in_fire) begin
        setup_step <= SU_RIGHT;
        clr_addr   <= '0;
        walk_row   <= '0;
        walk_col   <= '0;
      end
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (state == ST_SETUP) begin
        unique case (setup_step)
          SU_RIGHT:     setup_step <= SU_BOTTOM;
          SU_BOTTOM:    setup_step <= SU_LEFT_IN;
          SU_LEFT_IN:   setup_step <= SU_RIGHT_IN;
          SU_RIGHT_IN:  setup_step <= SU_TOP_IN;
          SU_TOP_IN:    setup_step <= SU_BOTTOM_IN;
          SU_BOTTOM_IN: setup_step <= SU_RIGHT;
          default:      setup_step <= SU_RIGHT;
        endcase
      end
      // Row and column walk
      if (state == ST_ROW && !cmp_in && !row_last) begin
        walk_row <= walk_row + ROW_W'(1);
      end
      if (state == ST_COL) begin
        if (col_last) begin
          walk_col <= '0;
          if (!row_last) walk_row <= walk_row + ROW_W'(1);
        end else begin
          walk_col <= walk_col + COL_W'(1);
        end
      end
      // Output register
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_fire) begin
      cmd_q       <= cmd_t'(in_ch.command);
      paint_q     <= in_ch.paint_char;
      rd_row_q    <= in_ch.read_row;
      rd_col_q    <= in_ch.read_col;
      x_lo        <= CMP_W'(in_ch.rect_left);
      y_lo        <= CMP_W'(in_ch.rect_top);
      span_x_q    <= CMP_W'(in_ch.rect_span_x);
      span_y_q    <= CMP_W'(in_ch.rect_span_y);
      pend_pix    <= '0;
      pend_status <= (cmd_t'(in_ch.command) == CMD_OUTLINE ||
                      cmd_t'(in_ch.command) == CMD_FILL) && bad_rect;
    end
    if (state == ST_SETUP) begin
      unique case (setup_step)
        SU_RIGHT:     x_hi   <= add_sum;
        SU_BOTTOM:    y_hi   <= add_sum;
        SU_LEFT_IN:   x_lo_e <= add_sum;
        SU_RIGHT_IN:  x_hi_e <= add_sum;
        SU_TOP_IN:    y_lo_e <= add_sum;
        SU_BOTTOM_IN: y_hi_e <= add_sum;
        default: ;
      endcase
    end
    if (state == ST_ROW) begin
      row_edge <= cmp_edge;
    end
    if (state == ST_RDATA) begin
      pend_pix <= ram_rdata;
    end
    if (state == ST_DONE && out_free) begin
      out_pix    <= pend_pix;
      out_status <= pend_status;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.pixel_char = out_pix;
  assign out_ch.status     = out_status;

  // Canvas store
  rrc_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (DEPTH)
  ) u_canvas (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

endmodule

>>> design/rrc_checker.sv
// Port-level checks for the rectangle raster canvas, bound to the top level.
// Depends on rrc_pkg and rectangle_raster_canvas.
module rrc_checker
  import rrc_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] pixel_char,
  input logic              status
);

  // A taken command keeps the block busy for at least the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("command taken on back-to-back cycles");

  // An error word never carries pixel data
  a_error_no_pixel: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> pixel_char == '0)
    else $error("error word with nonzero pixel");

  // Nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word after reset");

  // A stalled result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pixel_char) && $stable(status))
    else $error("stalled result word changed");

endmodule

bind rectangle_raster_canvas rrc_checker u_rrc_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .pixel_char (out_ch.pixel_char),
  .status     (out_ch.status)
);
